@@ hw/rtl/a85_pkg.sv @@
// ----------------------------------------------------------------------------
// a85_pkg
// Types, character codes and the base-85 weight table shared by the
// ascii85 stream decoder.
// ----------------------------------------------------------------------------
package a85_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [2:0] status;
		logic       last_of_run;
	} out_item_t;

	// One unit of work handed from the front end to the back end:
	// nbytes decoded bytes from word (msb first), then a status beat if
	// status is not running.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic [2:0]  status;
	} job_t;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_OK    = 3'd1;
	localparam logic [2:0] ST_BAD   = 3'd2;
	localparam logic [2:0] ST_ZMID  = 3'd3;
	localparam logic [2:0] ST_TILDE = 3'd4;

	localparam logic [7:0] CH_FIRST = 8'h21; // '!'
	localparam logic [7:0] CH_LAST  = 8'h75; // 'u'
	localparam logic [7:0] CH_Z     = 8'h7A; // 'z'
	localparam logic [7:0] CH_TILDE = 8'h7E; // '~'
	localparam logic [7:0] CH_GT    = 8'h3E; // '>'
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;

	localparam int unsigned GROUP_DIGITS = 5;

	// weight of digit position idx, most significant position first
	function automatic logic [25:0] pow85(input logic [2:0] idx);
		logic [25:0] w;
		unique case (idx)
			3'd0:    w = 26'd52200625;
			3'd1:    w = 26'd614125;
			3'd2:    w = 26'd7225;
			3'd3:    w = 26'd85;
			default: w = 26'd1;
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/a85_front.sv @@
// ----------------------------------------------------------------------------
// a85_front
// Accepts one encoded character per beat, classifies it, keeps the group
// accumulator and emits one job per character that yields output.
// ----------------------------------------------------------------------------
module a85_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  a85_pkg::in_item_t in_data,
	input  logic              q_full,
	output logic              push,
	output a85_pkg::job_t     push_job
);
	import a85_pkg::*;

	logic [32:0] sum_q, sum_d, sum_nx, prod, addend;
	logic [2:0]  cnt_q, cnt_d, idx, pw_sel;
	logic        tilde_q, tilde_d;
	logic [25:0] pw;
	logic [6:0]  digit;
	logic [7:0]  ch;
	logic        eoi, is_digit, is_ws, accept;
	job_t        job;

	always_comb begin
		ch       = in_data.in_byte;
		eoi      = in_data.end_of_input;
		is_digit = (ch >= CH_FIRST) && (ch <= CH_LAST);
		is_ws    = (ch == CH_LF) || (ch == CH_CR) || (ch == CH_TAB) || (ch == CH_SP) ||
		           (ch == CH_NUL) || (ch == CH_FF) || (ch == CH_BS) || (ch == CH_DEL);
		idx      = (cnt_q < 3'(GROUP_DIGITS)) ? cnt_q : 3'(GROUP_DIGITS - 1);
		digit    = 7'(ch - CH_FIRST);
		// one adder: digit weight while accumulating, rounding term on flush
		pw_sel   = tilde_q ? 3'(cnt_q - 3'd1) : idx;
		pw       = pow85(pw_sel);
		prod     = 33'(digit) * 33'(pw);
		addend   = tilde_q ? 33'(pw) : prod;
		sum_nx   = 33'(sum_q + addend);

		job      = '0;
		job.status = ST_RUN;
		sum_d    = sum_q;
		cnt_d    = cnt_q;
		tilde_d  = tilde_q;

		priority if (tilde_q) begin
			if (ch == CH_GT && cnt_q != 3'd0 && cnt_q < 3'(GROUP_DIGITS)) begin
				job.word   = sum_nx[31:0];
				job.nbytes = 3'(cnt_q - 3'd1);
			end
			job.status = ST_OK;
		end else if (is_digit) begin
			if (idx == 3'(GROUP_DIGITS - 1)) begin
				job.word   = sum_nx[31:0];
				job.nbytes = 3'd4;
				sum_d      = '0;
				cnt_d      = '0;
			end else begin
				sum_d = sum_nx;
				cnt_d = 3'(idx + 3'd1);
			end
			if (eoi) job.status = ST_OK;
		end else if (ch == CH_Z) begin
			if (cnt_q != 3'd0) begin
				job.status = ST_ZMID;
			end else begin
				job.nbytes = 3'd4;
				if (eoi) job.status = ST_OK;
			end
		end else if (ch == CH_TILDE) begin
			if (eoi) job.status = ST_TILDE;
			else tilde_d = 1'b1;
		end else if (is_ws) begin
			if (eoi) job.status = ST_OK;
		end else begin
			job.status = ST_BAD;
		end

		// stream finished: back to idle
		if (job.status != ST_RUN) begin
			sum_d   = '0;
			cnt_d   = '0;
			tilde_d = 1'b0;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (job.nbytes != 3'd0 || job.status != ST_RUN);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			cnt_q   <= '0;
			tilde_q <= 1'b0;
		end else if (accept) begin
			sum_q   <= sum_d;
			cnt_q   <= cnt_d;
			tilde_q <= tilde_d;
		end
	end

endmodule

@@ hw/rtl/a85_queue.sv @@
// ----------------------------------------------------------------------------
// a85_queue
// Small job queue between front end and back end; head is read directly.
// ----------------------------------------------------------------------------
module a85_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  a85_pkg::job_t push_job,
	input  logic          pop,
	output a85_pkg::job_t head,
	output logic          empty,
	output logic          full
);
	import a85_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
			if (push && !pop)      count_q <= CNT_W'(count_q + 1'b1);
			else if (pop && !push) count_q <= CNT_W'(count_q - 1'b1);
		end
	end

endmodule

@@ hw/rtl/a85_back.sv @@
// ----------------------------------------------------------------------------
// a85_back
// Walks the head job one beat per cycle unless the output stalls: its bytes
// msb first, then the status beat if the job ends the stream. Registered output.
// ----------------------------------------------------------------------------
module a85_back (
	input  logic               clk,
	input  logic               arst_n,
	input  a85_pkg::job_t      head,
	input  logic               job_avail,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output a85_pkg::out_item_t out_data
);
	import a85_pkg::*;

	logic [2:0] k_q;
	logic       valid_q, take, is_byte;
	out_item_t  out_q, item;

	always_comb begin
		is_byte = (k_q < head.nbytes);
		item    = '0;
		if (is_byte) begin
			unique case (k_q[1:0])
				2'd0: item.out_byte = head.word[31:24];
				2'd1: item.out_byte = head.word[23:16];
				2'd2: item.out_byte = head.word[15:8];
				2'd3: item.out_byte = head.word[7:0];
			endcase
			item.byte_valid  = 1'b1;
			item.status      = ST_RUN;
			item.last_of_run = (3'(k_q + 3'd1) == head.nbytes) && (head.status == ST_RUN);
		end else begin
			item.status      = head.status;
			item.last_of_run = 1'b1;
		end
	end

	assign take      = job_avail && (!valid_q || out_ready);
	assign pop       = take && item.last_of_run;
	assign out_valid = valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (take) out_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			k_q     <= item.last_of_run ? 3'd0 : 3'(k_q + 3'd1);
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/ascii85_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// ascii85_stream_decoder
// An accepted character's job is written into the job queue, and the back end
// then registers its beats; one result beat per cycle unless out_ready stalls.
// Throughput: one character per cycle while the job queue has room; a job
// of n bytes yields n byte beats, so 'z' bursts can fill the queue and stall input.
// Reset: arst_n clears the group accumulator, queue pointers and output
// valid; the decoder starts a fresh stream.
// ----------------------------------------------------------------------------
module ascii85_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  a85_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output a85_pkg::out_item_t out_data
);
	import a85_pkg::*;

	logic push, pop, q_empty, q_full;
	job_t push_job, head;

	a85_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	a85_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	a85_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.job_avail (!q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("job pushed into full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.byte_valid) |->
			(out_data.last_of_run && out_data.status != ST_RUN))
		else $error("status beat without final status");

	a_byte_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.byte_valid) |-> (out_data.status == ST_RUN))
		else $error("data beat with nonzero status");

endmodule
